// ----- hdl/fbpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared widths, register indexes, status codes and types of the block pool
// allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int MAX_BLOCKS   = 256;
    localparam int MIN_BLOCKS   = 2;
    localparam int BLK_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
    localparam int WAITER_DEPTH = 16;
    localparam int WQ_PTR_W     = $clog2(WAITER_DEPTH);
    localparam int WQ_CNT_W     = $clog2(WAITER_DEPTH + 1);
    localparam int REQ_W        = 8;
    localparam int ADDR_W       = 32;
    localparam int SIZE_W       = 16;
    localparam int STATUS_W     = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

    // register reset values
    localparam logic [ADDR_W-1:0] BASE_RESET  = '0;
    localparam logic [SIZE_W-1:0] BYTES_RESET = 16'd16;
    localparam logic [CNT_W-1:0]  COUNT_RESET = CNT_W'(MAX_BLOCKS);

    // request kinds
    localparam logic KIND_GET     = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_HANDOFF   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_WQ_FULL   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd6;

    // free list head and link of block zero straight after an initialisation
    localparam logic [BLK_W-1:0] HEAD_RESET      = '0;
    localparam logic [BLK_W-1:0] HEAD_NEXT_RESET = BLK_W'(1);

    typedef struct packed {
        logic              kind;
        logic              may_wait;
        logic [REQ_W-1:0]  requester_id;
        logic [BLK_W-1:0]  block_index;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BLK_W-1:0]    out_index;
        logic [ADDR_W-1:0]   out_address;
        logic [REQ_W-1:0]    waiter_id;
        logic [CNT_W-1:0]    free_left;
    } result_t;

    typedef struct packed {
        logic             rd_en;
        logic [BLK_W-1:0] rd_addr;
        logic             wr_en;
        logic [BLK_W-1:0] wr_addr;
        logic [BLK_W-1:0] wr_data;
    } link_op_t;

    typedef struct packed {
        logic             push;
        logic [REQ_W-1:0] push_id;
        logic             pop;
    } wq_op_t;

    // block count clamped to the supported range
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] res;
        res = cnt;
        if (cnt < CNT_W'(MIN_BLOCKS))
        begin
            res = CNT_W'(MIN_BLOCKS);
        end
        else if (cnt > CNT_W'(MAX_BLOCKS))
        begin
            res = CNT_W'(MAX_BLOCKS);
        end
        return res;
    endfunction

endpackage

// ----- hdl/fbpa_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_req_if
// Request channel: get or release of one block.
// ----------------------------------------------------------------------------
interface fbpa_req_if import fbpa_pkg::*;;
    logic             valid;
    logic             ready;
    logic             kind;
    logic             may_wait;
    logic [REQ_W-1:0] requester_id;
    logic [BLK_W-1:0] block_index;

    modport source (output valid, kind, may_wait, requester_id, block_index,
                    input ready);
    modport sink   (input valid, kind, may_wait, requester_id, block_index,
                    output ready);
endinterface

// ----- hdl/fbpa_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_rsp_if
// Response channel: one result for each request.
// ----------------------------------------------------------------------------
interface fbpa_rsp_if import fbpa_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BLK_W-1:0]    out_index;
    logic [ADDR_W-1:0]   out_address;
    logic [REQ_W-1:0]    waiter_id;
    logic [CNT_W-1:0]    free_left;

    modport source (output valid, status, out_index, out_address, waiter_id,
                    free_left, input ready);
    modport sink   (input valid, status, out_index, out_address, waiter_id,
                    free_left, output ready);
endinterface

// ----- hdl/fbpa_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface fbpa_cfg_if import fbpa_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/fixed_block_pool_allocator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core
// Pool of equal-size blocks kept on a LIFO free list, with a FIFO of waiting
// requesters that receive released blocks directly.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                             | handshake
//  req     | in  | kind, may_wait, requester_id, block_index           | valid/ready
//  rsp     | out | status, out_index, out_address, waiter_id, free_left| valid/ready
//  cfg     | in  | index, data                                         | valid/ready
//
// One request per cycle sustained while the response is not stalled; each
// result is loaded into the result register from the input register.
// The free list head link is read ahead from the link table through its
// registered port, so back-to-back gets never wait on the table.
// Reset or a write to a defined register index re-initialises the pool.
// A stalled response holds only the result register; the input register still
// takes one more request.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_core import fbpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    fbpa_req_if.sink   req,
    fbpa_rsp_if.source rsp,
    fbpa_cfg_if.sink   cfg
);

    logic                in_vld_reg;
    item_t               item_reg;
    logic                out_vld_reg;
    result_t             res_reg;
    logic [BLK_W-1:0]    head_reg;
    logic [CNT_W-1:0]    free_reg;
    logic [ADDR_W-1:0]   base_reg;
    logic [SIZE_W-1:0]   bytes_reg;
    logic [CNT_W-1:0]    count_reg;

    logic                advance;
    logic                cfg_hit;
    logic [CNT_W-1:0]    count_eff;
    logic [CNT_W-1:0]    count_after_cfg;
    logic [BLK_W-1:0]    head_next;
    logic [BLK_W-1:0]    head_new;
    logic [CNT_W-1:0]    free_new;
    logic [WQ_CNT_W-1:0] wq_total;
    logic [REQ_W-1:0]    wq_head_id;
    link_op_t            link_op;
    link_op_t            link_op_g;
    wq_op_t              wq_op;
    wq_op_t              wq_op_g;
    result_t             dec_res;

    // handshake control
    assign advance   = in_vld_reg && (!out_vld_reg || rsp.ready);
    assign req.ready = !in_vld_reg || advance;
    assign cfg.ready = 1'b1;
    assign cfg_hit   = cfg.valid && (cfg.index <= CFG_COUNT);
    assign count_eff = eff_count(count_reg);
    assign count_after_cfg = (cfg.index == CFG_COUNT) ?
                             eff_count(cfg.data[CNT_W-1:0]) : count_eff;

    // state updates only for a request that moves on
    assign link_op_g = advance ? link_op : '0;
    assign wq_op_g   = advance ? wq_op : '0;

    fbpa_link_ram u_link_ram
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (cfg_hit),
        .op        (link_op_g),
        .head_next (head_next)
    );

    fbpa_waitq u_waitq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (cfg_hit),
        .op      (wq_op_g),
        .head_id (wq_head_id),
        .total   (wq_total)
    );

    fbpa_decide u_decide
    (
        .item         (item_reg),
        .head         (head_reg),
        .head_next    (head_next),
        .free_total   (free_reg),
        .count_eff    (count_eff),
        .wq_total     (wq_total),
        .wq_head_id   (wq_head_id),
        .base_address (base_reg),
        .block_bytes  (bytes_reg),
        .head_new     (head_new),
        .free_new     (free_new),
        .link_op      (link_op),
        .wq_op        (wq_op),
        .res          (dec_res)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_vld_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            item_reg.kind         <= req.kind;
            item_reg.may_wait     <= req.may_wait;
            item_reg.requester_id <= req.requester_id;
            item_reg.block_index  <= req.block_index;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= dec_res;
        end
    end

    // configuration registers and free list head
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= BASE_RESET;
            bytes_reg <= BYTES_RESET;
            count_reg <= COUNT_RESET;
            head_reg  <= HEAD_RESET;
            free_reg  <= eff_count(COUNT_RESET);
        end
        else if (cfg_hit)
        begin
            case (cfg.index)
                CFG_BASE:  base_reg  <= cfg.data[ADDR_W-1:0];
                CFG_BYTES: bytes_reg <= cfg.data[SIZE_W-1:0];
                CFG_COUNT: count_reg <= cfg.data[CNT_W-1:0];
                default:   base_reg  <= base_reg;
            endcase
            head_reg <= HEAD_RESET;
            free_reg <= count_after_cfg;
        end
        else if (advance)
        begin
            head_reg <= head_new;
            free_reg <= free_new;
        end
    end

    // response outputs
    assign rsp.valid       = out_vld_reg;
    assign rsp.status      = res_reg.status;
    assign rsp.out_index   = res_reg.out_index;
    assign rsp.out_address = res_reg.out_address;
    assign rsp.waiter_id   = res_reg.waiter_id;
    assign rsp.free_left   = res_reg.free_left;

    // free count never above the pool size
    assert property (@(posedge clk) disable iff (!rst_n) free_reg <= count_eff)
        else $error("free count exceeds pool size");

    // requesters only wait while the pool is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (wq_total != '0) |-> (free_reg == '0))
        else $error("waiters queued while blocks are free");

    // a handoff removes exactly one waiter
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !cfg_hit && dec_res.status == ST_HANDOFF) |=>
        (wq_total == $past(wq_total) - WQ_CNT_W'(1)))
        else $error("handoff did not pop the waiter queue");

    // a grant on a get takes one block off the free count
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !cfg_hit && item_reg.kind == KIND_GET &&
         dec_res.status == ST_GRANTED) |=>
        (free_reg == $past(free_reg) - CNT_W'(1)))
        else $error("grant did not decrement the free count");

endmodule

// ----- hdl/fbpa_link_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_link_ram
// Free list link table with registered read. Keeps the link of the current
// free list head available every cycle, forwarding on pushes.
// ----------------------------------------------------------------------------
module fbpa_link_ram import fbpa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  link_op_t         op,
    output logic [BLK_W-1:0] head_next
);

    logic [BLK_W-1:0]      mem [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] valid_reg;
    logic [BLK_W-1:0]      rd_mem_reg;
    logic [BLK_W-1:0]      rd_addr_reg;
    logic                  rd_vld_reg;
    logic                  fwd_reg;
    logic [BLK_W-1:0]      fwd_data_reg;

    // link of the head: forwarded value, stored entry, or default successor
    always_comb
    begin
        if (fwd_reg)
        begin
            head_next = fwd_data_reg;
        end
        else if (rd_vld_reg)
        begin
            head_next = rd_mem_reg;
        end
        else
        begin
            head_next = rd_addr_reg + BLK_W'(1);
        end
    end

    // storage array
    always_ff @(posedge clk)
    begin
        if (op.wr_en && !clear)
        begin
            mem[op.wr_addr] <= op.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (op.rd_en && !clear)
        begin
            rd_mem_reg  <= mem[op.rd_addr];
            rd_vld_reg  <= valid_reg[op.rd_addr];
            rd_addr_reg <= op.rd_addr;
        end
    end

    // written flags and forwarding control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            fwd_reg      <= 1'b1;
            fwd_data_reg <= HEAD_NEXT_RESET;
        end
        else if (clear)
        begin
            valid_reg    <= '0;
            fwd_reg      <= 1'b1;
            fwd_data_reg <= HEAD_NEXT_RESET;
        end
        else if (op.rd_en)
        begin
            fwd_reg <= 1'b0;
        end
        else if (op.wr_en)
        begin
            valid_reg[op.wr_addr] <= 1'b1;
            fwd_reg               <= 1'b1;
            fwd_data_reg          <= op.wr_data;
        end
    end

endmodule

// ----- hdl/fbpa_waitq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_waitq
// FIFO of requesters waiting for a block while the pool is empty.
// ----------------------------------------------------------------------------
module fbpa_waitq import fbpa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  wq_op_t              op,
    output logic [REQ_W-1:0]    head_id,
    output logic [WQ_CNT_W-1:0] total
);

    logic [REQ_W-1:0]    fifo_reg [WAITER_DEPTH];
    logic [WQ_PTR_W-1:0] rd_ptr_reg;
    logic [WQ_CNT_W-1:0] total_reg;
    logic [WQ_PTR_W-1:0] wr_ptr;

    assign wr_ptr  = rd_ptr_reg + total_reg[WQ_PTR_W-1:0];
    assign head_id = fifo_reg[rd_ptr_reg];
    assign total   = total_reg;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (op.push && !clear)
        begin
            fifo_reg[wr_ptr] <= op.push_id;
        end
    end

    // pointer and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            total_reg  <= '0;
        end
        else if (clear)
        begin
            rd_ptr_reg <= '0;
            total_reg  <= '0;
        end
        else if (op.push)
        begin
            total_reg <= total_reg + WQ_CNT_W'(1);
        end
        else if (op.pop)
        begin
            rd_ptr_reg <= rd_ptr_reg + WQ_PTR_W'(1);
            total_reg  <= total_reg - WQ_CNT_W'(1);
        end
    end

endmodule

// ----- hdl/fbpa_decide.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_decide
// Per-request decision: picks the outcome, the state updates and the block
// address for one get or release.
// ----------------------------------------------------------------------------
module fbpa_decide import fbpa_pkg::*;
(
    input  item_t               item,
    input  logic [BLK_W-1:0]    head,
    input  logic [BLK_W-1:0]    head_next,
    input  logic [CNT_W-1:0]    free_total,
    input  logic [CNT_W-1:0]    count_eff,
    input  logic [WQ_CNT_W-1:0] wq_total,
    input  logic [REQ_W-1:0]    wq_head_id,
    input  logic [ADDR_W-1:0]   base_address,
    input  logic [SIZE_W-1:0]   block_bytes,
    output logic [BLK_W-1:0]    head_new,
    output logic [CNT_W-1:0]    free_new,
    output link_op_t            link_op,
    output wq_op_t              wq_op,
    output result_t             res
);

    localparam int PROD_W = BLK_W + SIZE_W - 2;

    logic [BLK_W-1:0]  addr_idx;
    logic              use_addr;
    logic [PROD_W-1:0] prod;
    logic [ADDR_W-1:0] addr;

    // byte address of the selected block, size taken in whole words
    assign prod = PROD_W'(addr_idx) * PROD_W'(block_bytes[SIZE_W-1:2]);
    assign addr = base_address + ADDR_W'({prod, 2'b00});

    // outcome selection
    always_comb
    begin
        head_new  = head;
        free_new  = free_total;
        link_op   = '0;
        wq_op     = '0;
        addr_idx  = item.block_index;
        use_addr  = 1'b0;
        res       = '0;
        if (item.kind == KIND_GET)
        begin
            if (free_total != '0)
            begin
                res.status    = ST_GRANTED;
                res.out_index = head;
                addr_idx      = head;
                use_addr      = 1'b1;
                head_new      = head_next;
                free_new      = free_total - CNT_W'(1);
                link_op.rd_en   = 1'b1;
                link_op.rd_addr = head_next;
            end
            else if (!item.may_wait)
            begin
                res.status = ST_EMPTY;
            end
            else if (wq_total >= WQ_CNT_W'(WAITER_DEPTH))
            begin
                res.status = ST_WQ_FULL;
            end
            else
            begin
                res.status    = ST_QUEUED;
                wq_op.push    = 1'b1;
                wq_op.push_id = item.requester_id;
            end
        end
        else
        begin
            if (CNT_W'(item.block_index) >= count_eff)
            begin
                res.status = ST_BAD_INDEX;
            end
            else if (wq_total != '0)
            begin
                res.status    = ST_HANDOFF;
                res.out_index = item.block_index;
                res.waiter_id = wq_head_id;
                use_addr      = 1'b1;
                wq_op.pop     = 1'b1;
            end
            else if (free_total < count_eff)
            begin
                res.status      = ST_GRANTED;
                head_new        = item.block_index;
                free_new        = free_total + CNT_W'(1);
                link_op.wr_en   = 1'b1;
                link_op.wr_addr = item.block_index;
                link_op.wr_data = head;
            end
            else
            begin
                res.status = ST_OVERFLOW;
            end
        end
        res.out_address = use_addr ? addr : '0;
        res.free_left   = free_new;
    end

endmodule

// ----- test/fixed_block_pool_allocator_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core_test
// Self-checking bench for the block pool allocator. A clocked driver feeds
// get and release requests from a queue, a clocked monitor checks every
// response against a cycle-free model of the free list and the waiter FIFO.
// Directed requests cover overflow, double release, bad index, empty pool,
// queueing and handoff; random phases over several pool settings follow.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_core_test;
    import fbpa_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 6;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_ITEMS  = 250;
    localparam int NUM_PHASES   = 7;

    // index past the register list, must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    fbpa_req_if req_ch ();
    fbpa_rsp_if rsp_ch ();
    fbpa_cfg_if cfg_ch ();

    fixed_block_pool_allocator_core dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // pending requests and expected responses
    item_t   pool_req_q[$];
    result_t pool_result_q[$];

    int fail_count   = 0;
    int stall_cycles = 0;
    int req_idle_pct = 0;
    int rsp_idle_pct = 0;

    // model of the pool
    logic [ADDR_W-1:0]   reg_base;
    logic [SIZE_W-1:0]   reg_bytes;
    logic [CNT_W-1:0]    reg_count;
    logic [BLK_W-1:0]    pool_link [MAX_BLOCKS];
    logic [BLK_W-1:0]    pool_head;
    logic [CNT_W-1:0]    pool_free;
    logic [REQ_W-1:0]    wait_ids [WAITER_DEPTH];
    logic [WQ_PTR_W-1:0] wait_rd;
    logic [WQ_CNT_W-1:0] wait_cnt;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // block count held to the supported range
    function automatic int clamp_count(logic [CNT_W-1:0] n);
        int c;
        c = int'(n);
        if (c < MIN_BLOCKS)
        begin
            c = MIN_BLOCKS;
        end
        else if (c > MAX_BLOCKS)
        begin
            c = MAX_BLOCKS;
        end
        return c;
    endfunction

    function automatic logic [ADDR_W-1:0] block_address(logic [BLK_W-1:0] idx);
        return reg_base + ADDR_W'(idx) * ADDR_W'({reg_bytes[SIZE_W-1:2], 2'b00});
    endfunction

    // free list back to ascending order, waiters dropped
    task automatic init_pool();
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            pool_link[i] = BLK_W'(i + 1);
        end
        pool_head = '0;
        pool_free = CNT_W'(clamp_count(reg_count));
        wait_rd   = '0;
        wait_cnt  = '0;
    endtask

    // model one request, return its response
    function automatic result_t pool_serve(item_t it);
        result_t             r;
        int                  cnt;
        logic [WQ_PTR_W-1:0] slot;
        r   = '0;
        cnt = clamp_count(reg_count);
        if (it.kind == KIND_GET)
        begin
            if (pool_free != '0)
            begin
                r.status      = ST_GRANTED;
                r.out_index   = pool_head;
                r.out_address = block_address(pool_head);
                pool_head     = pool_link[pool_head];
                pool_free     = pool_free - CNT_W'(1);
            end
            else if (!it.may_wait)
            begin
                r.status = ST_EMPTY;
            end
            else if (int'(wait_cnt) >= WAITER_DEPTH)
            begin
                r.status = ST_WQ_FULL;
            end
            else
            begin
                slot           = wait_rd + WQ_PTR_W'(wait_cnt);
                wait_ids[slot] = it.requester_id;
                wait_cnt       = wait_cnt + WQ_CNT_W'(1);
                r.status       = ST_QUEUED;
            end
        end
        else
        begin
            if (int'(it.block_index) >= cnt)
            begin
                r.status = ST_BAD_INDEX;
            end
            else if (wait_cnt != '0)
            begin
                r.status      = ST_HANDOFF;
                r.waiter_id   = wait_ids[wait_rd];
                r.out_index   = it.block_index;
                r.out_address = block_address(it.block_index);
                wait_rd       = wait_rd + WQ_PTR_W'(1);
                wait_cnt      = wait_cnt - WQ_CNT_W'(1);
            end
            else if (int'(pool_free) < cnt)
            begin
                r.status                 = ST_GRANTED;
                pool_link[it.block_index] = pool_head;
                pool_head                = it.block_index;
                pool_free                = pool_free + CNT_W'(1);
            end
            else
            begin
                r.status = ST_OVERFLOW;
            end
        end
        r.free_left = pool_free;
        return r;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        item_t nxt;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                pool_result_q.push_back(pool_serve(pool_req_q.pop_front()));
            end
            if (!(req_ch.valid && !req_ch.ready))
            begin
                if (pool_req_q.size() > 0 && $urandom_range(99) >= req_idle_pct)
                begin
                    nxt                 = pool_req_q[0];
                    req_ch.valid        <= 1'b1;
                    req_ch.kind         <= nxt.kind;
                    req_ch.may_wait     <= nxt.may_wait;
                    req_ch.requester_id <= nxt.requester_id;
                    req_ch.block_index  <= nxt.block_index;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        result_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pool_result_q.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (fail_count <= MAX_REPORTS)
                    begin
                        $display("unexpected response: status %0d index %0d",
                                 rsp_ch.status, rsp_ch.out_index);
                    end
                end
                else
                begin
                    want = pool_result_q.pop_front();
                    if (rsp_ch.status !== want.status ||
                        rsp_ch.out_index !== want.out_index ||
                        rsp_ch.out_address !== want.out_address ||
                        rsp_ch.waiter_id !== want.waiter_id ||
                        rsp_ch.free_left !== want.free_left)
                    begin
                        fail_count = fail_count + 1;
                        if (fail_count <= MAX_REPORTS)
                        begin
                            $display("mismatch at %0t: expected status %0d index %0d %s",
                                     $realtime, want.status, want.out_index,
                                     $sformatf("addr %h waiter %0d free %0d",
                                               want.out_address, want.waiter_id,
                                               want.free_left));
                            $display("  actual   status %0d index %0d %s",
                                     rsp_ch.status, rsp_ch.out_index,
                                     $sformatf("addr %h waiter %0d free %0d",
                                               rsp_ch.out_address, rsp_ch.waiter_id,
                                               rsp_ch.free_left));
                        end
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_req(logic kind, logic may_wait, logic [REQ_W-1:0] id,
                             logic [BLK_W-1:0] idx);
        item_t it;
        it.kind         = kind;
        it.may_wait     = may_wait;
        it.requester_id = id;
        it.block_index  = idx;
        pool_req_q.push_back(it);
    endtask

    // random requests in runs of changing get/release balance
    task automatic queue_random(int n, int cnt);
        int    run_left;
        int    get_pct;
        item_t it;
        run_left = 0;
        get_pct  = 50;
        for (int i = 0; i < n; i++)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(40, 5);
                get_pct  = $urandom_range(90, 10);
            end
            run_left        = run_left - 1;
            it.kind         = ($urandom_range(99) < get_pct) ? KIND_GET : KIND_RELEASE;
            it.may_wait     = 1'($urandom_range(1));
            it.requester_id = REQ_W'($urandom_range(255));
            if (it.kind == KIND_RELEASE && $urandom_range(99) < 88)
            begin
                it.block_index = BLK_W'($urandom_range(cnt - 1));
            end
            else
            begin
                it.block_index = BLK_W'($urandom_range(255));
            end
            pool_req_q.push_back(it);
        end
    endtask

    // register write, only while nothing is in flight
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_BASE)
        begin
            reg_base = val;
            init_pool();
        end
        else if (idx == CFG_BYTES)
        begin
            reg_bytes = val[SIZE_W-1:0];
            init_pool();
        end
        else if (idx == CFG_COUNT)
        begin
            reg_count = val[CNT_W-1:0];
            init_pool();
        end
        @(negedge clk);
    endtask

    // wait until every request is taken and answered
    task automatic wait_drained();
        while (pool_req_q.size() > 0 || req_ch.valid || pool_result_q.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // stimulus
    initial
    begin
        logic [CNT_W-1:0]  cnt_val;
        logic [SIZE_W-1:0] bytes_val;
        logic [ADDR_W-1:0] base_val;

        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.kind         = KIND_GET;
        req_ch.may_wait     = 1'b0;
        req_ch.requester_id = '0;
        req_ch.block_index  = '0;
        rsp_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_BASE;
        cfg_ch.data         = '0;
        reg_base            = BASE_RESET;
        reg_bytes           = BYTES_RESET;
        reg_count           = COUNT_RESET;
        init_pool();
        req_idle_pct        = 20;
        rsp_idle_pct        = 64;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: release with all free, get, double release
        queue_req(KIND_RELEASE, 1'b0, 8'h00, 8'd0);
        queue_req(KIND_GET, 1'b0, 8'h00, 8'hFF);
        queue_req(KIND_RELEASE, 1'b1, 8'hFF, 8'd255);
        queue_req(KIND_GET, 1'b1, 8'hFF, 8'h00);
        queue_req(KIND_GET, 1'b0, 8'h00, 8'h00);
        wait_drained();

        // smallest pool, widest size, address wrap
        write_reg(CFG_COUNT, 32'd1);
        write_reg(CFG_BYTES, 32'h0000_FFFF);
        write_reg(CFG_BASE, 32'hFFFF_FFF0);
        queue_req(KIND_GET, 1'b0, 8'h01, 8'h00);
        queue_req(KIND_GET, 1'b0, 8'h02, 8'h00);
        queue_req(KIND_GET, 1'b0, 8'h03, 8'h00);
        queue_req(KIND_GET, 1'b1, 8'hA5, 8'h00);
        queue_req(KIND_GET, 1'b1, 8'h5A, 8'h00);
        queue_req(KIND_RELEASE, 1'b0, 8'h00, 8'd2);
        queue_req(KIND_RELEASE, 1'b1, 8'h00, 8'd255);
        queue_req(KIND_RELEASE, 1'b0, 8'h00, 8'd1);
        queue_req(KIND_RELEASE, 1'b0, 8'h00, 8'd0);
        queue_req(KIND_RELEASE, 1'b0, 8'h00, 8'd0);
        queue_req(KIND_RELEASE, 1'b0, 8'h00, 8'd0);
        queue_req(KIND_RELEASE, 1'b0, 8'h00, 8'd1);
        wait_drained();

        // write past the register list leaves the pool alone
        write_reg(CFG_NONE, $urandom);
        queue_req(KIND_GET, 1'b0, 8'h00, 8'h00);
        wait_drained();

        // random phases over several pool settings
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            base_val  = $urandom;
            bytes_val = SIZE_W'($urandom_range(65535));
            case (p)
                0:
                begin
                    cnt_val   = 9'd4;
                    bytes_val = 16'd4;
                    base_val  = 32'h0000_0000;
                end
                1:
                begin
                    cnt_val   = 9'h1FF;
                    bytes_val = 16'd65532;
                    base_val  = 32'hFFFF_FFFC;
                end
                2:
                begin
                    cnt_val = 9'd2;
                end
                3:
                begin
                    cnt_val = CNT_W'($urandom_range(24, 2));
                end
                4:
                begin
                    cnt_val   = 9'd0;
                    bytes_val = 16'd3;
                end
                5:
                begin
                    cnt_val   = CNT_W'($urandom_range(256, 2));
                    bytes_val = 16'hFFFF;
                end
                default:
                begin
                    cnt_val = 9'd16;
                end
            endcase

            if (p < 3)
            begin
                req_idle_pct = 20;
                rsp_idle_pct = 64;
            end
            else if (p < 5)
            begin
                req_idle_pct = 64;
                rsp_idle_pct = 20;
            end
            else
            begin
                req_idle_pct = 0;
                rsp_idle_pct = 0;
            end

            write_reg(CFG_BASE, base_val);
            write_reg(CFG_BYTES, {16'($urandom), bytes_val});
            write_reg(CFG_COUNT, {23'($urandom), cnt_val});

            // sender pauses half way until every response is back
            queue_random(PHASE_ITEMS / 2, clamp_count(cnt_val));
            wait_drained();
            queue_random(PHASE_ITEMS - PHASE_ITEMS / 2, clamp_count(cnt_val));
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pool_result_q.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
